FILE: rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam int SFR_MAX_FRAME = 16;
    localparam int JOB_DEPTH     = 2;
    localparam int NPARAM_W      = 5;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_TOO_LONG   = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_CHECKSUM   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT    = 3'd5;

    localparam logic [7:0] HDR_BYTE = 8'h55;

    localparam logic REG_TIMEOUT_TICKS = 1'b0;
    localparam logic REG_MAX_FRAME_LEN = 1'b1;

    typedef struct packed {
        logic                is_frame;
        logic [2:0]          status;
        logic [7:0]          servo_id;
        logic [7:0]          command;
        logic [4:0]          bytes_seen;
        logic [NPARAM_W-1:0] nparam;
    } sfr_job_t;

endpackage

FILE: rtl/core/sfr_job_fifo.sv
module sfr_job_fifo
    import sfr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  sfr_job_t push_job,
    output logic     full,
    input  logic     pop,
    output sfr_job_t pop_job,
    output logic     empty
);

    // The depth is a power of two, so the pointers simply wrap.
    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    sfr_job_t         entry_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = SFR_MAX_FRAME,
    parameter int AW        = $clog2(MAX_FRAME)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_cmd,
    input  logic [7:0]    in_byte,
    input  logic [15:0]   timeout_ticks,
    input  logic [4:0]    max_frame_len,
    output logic          push,
    output sfr_job_t      push_job,
    input  logic          fifo_full,
    input  logic          frame_done,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [8:0]    frame_total_reg, frame_total_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   tick_reg, tick_next;
    logic          armed_reg, armed_next;
    logic          hdr_ok_reg, hdr_ok_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    command_reg, command_next;
    logic          frame_pend_reg, frame_pend_next;

    logic          accept;
    logic [8:0]    limit;
    logic          fire;
    logic          frame_end;
    logic [2:0]    code;

    assign in_ready  = !fifo_full && !frame_pend_reg;
    assign accept    = in_valid && in_ready;
    assign limit     = (9'(max_frame_len) > 9'(MAX_FRAME)) ? 9'(MAX_FRAME)
                                                           : 9'(max_frame_len);
    assign mem_waddr = byte_count_reg[AW-1:0];
    assign mem_wdata = in_byte;

    always_comb begin
        byte_count_next  = byte_count_reg;
        frame_total_next = frame_total_reg;
        sum_next         = sum_reg;
        tick_next        = tick_reg;
        armed_next       = armed_reg;
        hdr_ok_next      = hdr_ok_reg;
        id_next          = id_reg;
        command_next     = command_reg;
        frame_pend_next  = frame_pend_reg && !frame_done;
        fire             = 1'b0;
        frame_end        = 1'b0;
        code             = ST_OK;
        mem_we           = 1'b0;
        push             = 1'b0;
        push_job         = '0;

        if (accept) begin
            unique case (in_cmd)
                CMD_START: begin
                    byte_count_next  = '0;
                    frame_total_next = '0;
                    sum_next         = '0;
                    tick_next        = '0;
                    armed_next       = 1'b1;
                end
                CMD_BYTE: begin
                    if (armed_reg) begin
                        if (byte_count_reg >= CW'(MAX_FRAME)) begin
                            fire = 1'b1;
                            code = ST_TOO_LONG;
                        end else begin
                            mem_we          = 1'b1;
                            byte_count_next = byte_count_reg + 1'b1;
                            if (byte_count_reg >= CW'(2) && (byte_count_reg < CW'(4)
                                    || 9'(byte_count_reg) + 9'd1 < frame_total_reg)) begin
                                sum_next = sum_reg + in_byte;
                            end
                            if (byte_count_reg == CW'(0)) begin
                                hdr_ok_next = (in_byte == HDR_BYTE);
                            end
                            if (byte_count_reg == CW'(1)) begin
                                hdr_ok_next = hdr_ok_reg && (in_byte == HDR_BYTE);
                            end
                            if (byte_count_reg == CW'(2)) begin
                                id_next = in_byte;
                            end
                            if (byte_count_reg == CW'(4)) begin
                                command_next = in_byte;
                            end
                            if (byte_count_next == CW'(4)) begin
                                frame_total_next = 9'(in_byte) + 9'd3;
                                priority if (!hdr_ok_reg) begin
                                    fire = 1'b1;
                                    code = ST_BAD_HEADER;
                                end else if (in_byte < 8'd3) begin
                                    fire = 1'b1;
                                    code = ST_BAD_LENGTH;
                                end else if (frame_total_next > limit) begin
                                    fire = 1'b1;
                                    code = ST_TOO_LONG;
                                end
                            end else if (byte_count_next > CW'(4)
                                    && 9'(byte_count_next) == frame_total_reg) begin
                                if (in_byte != ~sum_reg) begin
                                    fire = 1'b1;
                                    code = ST_CHECKSUM;
                                end else begin
                                    frame_end = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (armed_reg) begin
                        if (tick_reg != 16'hFFFF) begin
                            tick_next = tick_reg + 16'd1;
                        end
                        if (tick_next > timeout_ticks) begin
                            fire = 1'b1;
                            code = ST_TIMEOUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (fire) begin
            push                = 1'b1;
            armed_next          = 1'b0;
            push_job.is_frame   = 1'b0;
            push_job.status     = code;
            push_job.servo_id   = (byte_count_next > CW'(2)) ? id_next : 8'd0;
            push_job.command    = (byte_count_next > CW'(4)) ? command_next : 8'd0;
            push_job.bytes_seen = 5'(byte_count_next);
            push_job.nparam     = '0;
        end else if (frame_end) begin
            push                = 1'b1;
            armed_next          = 1'b0;
            push_job.is_frame   = 1'b1;
            push_job.status     = ST_OK;
            push_job.servo_id   = id_reg;
            push_job.command    = command_reg;
            push_job.bytes_seen = 5'd0;
            push_job.nparam     = NPARAM_W'(frame_total_reg - 9'd6);
            frame_pend_next     = (frame_total_reg != 9'd6);
        end
    end

    always_ff @(posedge aclk) begin
        hdr_ok_reg  <= hdr_ok_next;
        id_reg      <= id_next;
        command_reg <= command_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            frame_total_reg <= '0;
            sum_reg         <= '0;
            tick_reg        <= '0;
            armed_reg       <= 1'b0;
            frame_pend_reg  <= 1'b0;
        end else begin
            byte_count_reg  <= byte_count_next;
            frame_total_reg <= frame_total_next;
            sum_reg         <= sum_next;
            tick_reg        <= tick_next;
            armed_reg       <= armed_next;
            frame_pend_reg  <= frame_pend_next;
        end
    end

endmodule

FILE: rtl/core/sfr_back.sv
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = SFR_MAX_FRAME,
    parameter int AW        = $clog2(MAX_FRAME)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_pop,
    input  sfr_job_t      job,
    input  logic          mem_we,
    input  logic [AW-1:0] mem_waddr,
    input  logic [7:0]    mem_wdata,
    output logic          frame_done,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [39:0]   m_axis_tdata,  // servo_id, command, param_index, param_byte,
                                         // bytes_seen, zero fill
    output logic [3:0]    m_axis_tuser,  // status, param_valid
    output logic          m_axis_tlast
);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EMIT
    } bk_state_t;

    bk_state_t           state_reg;
    logic [7:0]          frame_mem [MAX_FRAME];
    logic [7:0]          rdata_reg;
    logic [NPARAM_W-1:0] idx_reg;
    logic [NPARAM_W-1:0] nparam_reg;
    logic [7:0]          id_reg;
    logic [7:0]          command_reg;

    logic                out_free;
    logic                last_param;
    logic [AW-1:0]       raddr;

    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign job_pop    = (state_reg == BK_IDLE) && job_valid && out_free;
    assign last_param = (idx_reg == nparam_reg - 1'b1);
    assign frame_done = (state_reg == BK_EMIT) && out_free && last_param;
    assign raddr      = AW'(7'(idx_reg) + 7'd5);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == BK_FETCH) begin
            rdata_reg <= frame_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE: begin
                    if (job_pop) begin
                        idx_reg     <= '0;
                        nparam_reg  <= job.nparam;
                        id_reg      <= job.servo_id;
                        command_reg <= job.command;
                        if (!job.is_frame || job.nparam == '0) begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tuser  <= {1'b0, job.status};
                            m_axis_tdata  <= {7'd0, job.bytes_seen, 8'd0, 4'd0,
                                              job.command, job.servo_id};
                            m_axis_tlast  <= 1'b1;
                        end else begin
                            state_reg <= BK_FETCH;
                        end
                    end
                end
                BK_FETCH: begin
                    state_reg <= BK_EMIT;
                end
                BK_EMIT: begin
                    if (out_free) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= {1'b1, ST_OK};
                        m_axis_tdata  <= {7'd0, 5'd0, rdata_reg, idx_reg[3:0],
                                          command_reg, id_reg};
                        m_axis_tlast  <= last_param;
                        if (last_param) begin
                            state_reg <= BK_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= BK_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/servo_frame_receiver.sv
// Serial servo reply deframer. Each input beat is a start command, a received byte or a
// one millisecond tick; the front end takes one beat per cycle while the queue has room
// and no frame is pending, checks the frame as bytes arrive and queues one job per
// finished frame or error into a two-entry queue. A status job (error, timeout, or a good
// frame without parameters) leaves as one result beat, registered when popped. A good
// frame with N parameters leaves as N beats via the registered read port of the frame
// store; from the checksum byte on, input is held off until the last parameter beat is
// registered. The store is not cleared after reset, so there is no initialization pass.
module servo_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = SFR_MAX_FRAME
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // servo_id, command, param_index, param_byte,
                                        // bytes_seen, zero fill
    output logic [3:0]  m_axis_tuser,   // status, param_valid
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_FRAME);

    logic [15:0]   timeout_ticks_reg;
    logic [4:0]    max_frame_len_reg;
    logic          cfg_write;

    logic          push;
    sfr_job_t      push_job;
    logic          fifo_full;
    logic          fifo_empty;
    logic          job_pop;
    sfr_job_t      pop_job;
    logic          frame_done;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_FRAME_LEN) ? {27'd0, max_frame_len_reg}
                                                       : {16'd0, timeout_ticks_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= 16'd100;
            max_frame_len_reg <= 5'd16;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                REG_MAX_FRAME_LEN: max_frame_len_reg <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    sfr_front #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_cmd        (s_axis_tuser),
        .in_byte       (s_axis_tdata),
        .timeout_ticks (timeout_ticks_reg),
        .max_frame_len (max_frame_len_reg),
        .push          (push),
        .push_job      (push_job),
        .fifo_full     (fifo_full),
        .frame_done    (frame_done),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata)
    );

    sfr_job_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty)
    );

    sfr_back #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (!fifo_empty),
        .job_pop       (job_pop),
        .job           (pop_job),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .frame_done    (frame_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/servo_frame_receiver_test.sv
`timescale 1ns / 100ps

module servo_frame_receiver_test;
    import sfr_pkg::*;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES     = 40;
    localparam int         LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_id;
        logic [7:0] command;
        logic       param_valid;
        logic [3:0] param_index;
        logic [7:0] param_byte;
        logic [4:0] bytes_seen;
        logic       last;
    } servo_result_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } rx_beat_t;

    typedef rx_beat_t beat_list_t[$];

    class servo_frame_scoreboard;
        servo_result_t expected_q[$];
        logic [7:0]    frame_bytes[SFR_MAX_FRAME];
        int unsigned   byte_cnt;
        int unsigned   frame_size;
        logic [7:0]    csum;
        logic [15:0]   ticks;
        bit            receiving;
        logic [15:0]   timeout_limit;
        logic [4:0]    size_limit;
        int            errors;
        int            beats_checked;
        int            good_frames;
        int            reports;

        function new();
            byte_cnt      = 0;
            frame_size    = 0;
            csum          = 8'h00;
            ticks         = 16'h0000;
            receiving     = 1'b0;
            timeout_limit = 16'd100;
            size_limit    = 5'd16;
            errors        = 0;
            beats_checked = 0;
            good_frames   = 0;
            reports       = 0;
        endfunction

        function logic [7:0] held(int unsigned pos);
            if (pos < byte_cnt && pos < SFR_MAX_FRAME) begin
                return frame_bytes[pos];
            end
            return 8'h00;
        endfunction

        function void push_status(logic [2:0] code);
            servo_result_t r;
            r            = '0;
            r.status     = code;
            r.servo_id   = held(2);
            r.command    = held(4);
            r.bytes_seen = 5'(byte_cnt);
            r.last       = 1'b1;
            expected_q.push_back(r);
            receiving = 1'b0;
        endfunction

        function void push_frame();
            servo_result_t r;
            int unsigned   nparam;
            nparam     = frame_size - 6;
            receiving  = 1'b0;
            r          = '0;
            r.status   = ST_OK;
            r.servo_id = held(2);
            r.command  = held(4);
            if (nparam == 0) begin
                r.last = 1'b1;
                expected_q.push_back(r);
                return;
            end
            for (int unsigned i = 0; i < nparam; i++) begin
                r.param_valid = 1'b1;
                r.param_index = 4'(i);
                r.param_byte  = held(5 + i);
                r.last        = (i + 1 == nparam);
                expected_q.push_back(r);
            end
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned pos;
            int unsigned limit;
            pos   = byte_cnt;
            limit = (size_limit > SFR_MAX_FRAME) ? SFR_MAX_FRAME : size_limit;
            if (pos >= SFR_MAX_FRAME) begin
                push_status(ST_TOO_LONG);
                return;
            end
            frame_bytes[pos] = b;
            byte_cnt = pos + 1;
            if (pos >= 2 && (pos < 4 || pos + 1 < frame_size)) begin
                csum = csum + b;
            end
            if (byte_cnt == 4) begin
                if (frame_bytes[0] != HDR_BYTE || frame_bytes[1] != HDR_BYTE) begin
                    push_status(ST_BAD_HEADER);
                end else if (frame_bytes[3] < 3) begin
                    push_status(ST_BAD_LENGTH);
                end else begin
                    frame_size = frame_bytes[3] + 3;
                    if (frame_size > limit) begin
                        push_status(ST_TOO_LONG);
                    end
                end
            end else if (byte_cnt > 4 && byte_cnt == frame_size) begin
                if (b != ~csum) begin
                    push_status(ST_CHECKSUM);
                end else begin
                    push_frame();
                end
            end
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] b);
            if (cmd == CMD_START) begin
                byte_cnt   = 0;
                frame_size = 0;
                csum       = 8'h00;
                ticks      = 16'h0000;
                receiving  = 1'b1;
            end else if (receiving) begin
                if (cmd == CMD_BYTE) begin
                    take_byte(b);
                end else if (cmd == CMD_TICK) begin
                    if (ticks != 16'hFFFF) begin
                        ticks = ticks + 16'd1;
                    end
                    if (ticks > timeout_limit) begin
                        push_status(ST_TIMEOUT);
                    end
                end
            end
        endfunction

        function void set_register(logic sel, logic [31:0] value);
            if (sel == REG_TIMEOUT_TICKS) begin
                timeout_limit = value[15:0];
            end else begin
                size_limit = value[4:0];
            end
        endfunction

        function string show(servo_result_t r);
            return {$sformatf("status=%0d id=%02h cmd=%02h pvalid=%0d ",
                              r.status, r.servo_id, r.command, r.param_valid),
                    $sformatf("index=%0d param=%02h seen=%0d last=%0d",
                              r.param_index, r.param_byte, r.bytes_seen, r.last)};
        endfunction

        function void check_result(logic [39:0] data, logic [3:0] user, logic tl);
            servo_result_t got;
            servo_result_t want;
            got.servo_id    = data[7:0];
            got.command     = data[15:8];
            got.param_index = data[19:16];
            got.param_byte  = data[27:20];
            got.bytes_seen  = data[32:28];
            got.status      = user[2:0];
            got.param_valid = user[3];
            got.last        = tl;
            beats_checked++;
            if (got.status != ST_OK) begin
                reports++;
            end else if (got.last) begin
                good_frames++;
            end
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result beat: %s", show(got));
                end
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("Result mismatch: expected %s", show(want));
                    $display("                 actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [1:0]  s_axis_tuser  = CMD_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    servo_frame_scoreboard sb;
    int   beats_sent  = 0;
    int   reg_writes  = 0;
    int   tx_calm     = 0;
    int   rx_calm     = 0;
    int   idle_cycles = 0;
    bit   no_gaps     = 1'b0;
    logic hold_due    = 1'b0;

    servo_frame_receiver u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rx_beat_t byte_beat(logic [7:0] b);
        return rx_beat_t'{CMD_BYTE, b};
    endfunction

    // A fill value with bit 8 set asks for random parameter bytes.
    function automatic beat_list_t build_frame(logic [7:0] id, logic [7:0] op, logic [7:0] len,
                                               int nparam, logic [8:0] fill);
        beat_list_t q;
        logic [7:0] csum;
        logic [7:0] p;
        csum = id + len + op;
        q.push_back(byte_beat(HDR_BYTE));
        q.push_back(byte_beat(HDR_BYTE));
        q.push_back(byte_beat(id));
        q.push_back(byte_beat(len));
        q.push_back(byte_beat(op));
        for (int i = 0; i < nparam; i++) begin
            p = fill[8] ? 8'($urandom) : fill[7:0];
            csum = csum + p;
            q.push_back(byte_beat(p));
        end
        q.push_back(byte_beat(~csum));
        return q;
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(cmd, b);
        beats_sent++;
    endtask

    task automatic send_list(input beat_list_t q, input int tick_pct);
        foreach (q[i]) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_beat(CMD_TICK, 8'($urandom));
            end
            send_beat(q[i].cmd, q[i].data);
        end
    endtask

    task automatic write_register(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(sel, value);
        reg_writes++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_sequence(input int limit, input int tick_pct);
        beat_list_t q;
        int kind;
        int maxp;
        int np;
        int cut;
        kind = $urandom_range(0, 99);
        maxp = (limit > 6) ? limit - 6 : 0;
        np   = ($urandom_range(0, 3) == 0) ? maxp : $urandom_range(0, maxp);
        q    = build_frame(8'($urandom), 8'($urandom), 8'(np + 3), np, 9'h100);
        if (kind < 66) begin
            cut = q.size();
        end else if (kind < 74) begin
            q[q.size() - 1].data = q[q.size() - 1].data ^ (8'h01 << $urandom_range(0, 7));
        end else if (kind < 80) begin
            q[$urandom_range(0, 1)].data = 8'($urandom);
        end else if (kind < 85) begin
            q[3].data = 8'($urandom_range(0, 2));
            while (q.size() > 4) void'(q.pop_back());
        end else if (kind < 90) begin
            q[3].data = 8'($urandom_range(limit - 2, 255));
            while (q.size() > 4) void'(q.pop_back());
        end else if (kind < 95) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end else begin
            q.delete();
            repeat ($urandom_range(1, 6)) q.push_back(rx_beat_t'{2'($urandom), 8'($urandom)});
        end
        q.push_front(rx_beat_t'{CMD_START, 8'($urandom)});
        send_list(q, tick_pct);
    endtask

    task automatic random_phase(input logic [15:0] timeout, input logic [4:0] max_len,
                                input int tick_pct, input int n, input bit hold);
        int target;
        int limit;
        write_register(REG_TIMEOUT_TICKS, 32'(timeout));
        write_register(REG_MAX_FRAME_LEN, 32'(max_len));
        limit = (max_len > SFR_MAX_FRAME) ? SFR_MAX_FRAME : max_len;
        if (hold) begin
            hold_due <= 1'b1;
        end
        target = beats_sent + n;
        while (beats_sent < target) random_sequence(limit, tick_pct);
        wait_idle();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing accepted for %0d cycles, %0d results outstanding.",
                     idle_cycles, sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls at random and, when asked, holds off for a long stretch.
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = pick_gap(rx_calm);
            if (hold_due) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_due <= 1'b0;
            end else if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        beat_list_t q;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_UNUSED, 8'hA5);
        send_beat(CMD_START, 8'h00);
        send_list(build_frame(8'h00, 8'h00, 8'd3, 0, 9'h000), 0);
        send_beat(CMD_START, 8'h00);
        q = {byte_beat(8'h55), byte_beat(8'hAA), byte_beat(8'h00), byte_beat(8'h05)};
        send_list(q, 0);
        send_beat(CMD_START, 8'h00);
        q = {byte_beat(HDR_BYTE), byte_beat(HDR_BYTE), byte_beat(8'hFE), byte_beat(8'h02)};
        send_list(q, 0);
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_BYTE, HDR_BYTE);
        send_beat(CMD_START, 8'hFF);
        q = {byte_beat(HDR_BYTE), byte_beat(HDR_BYTE), byte_beat(8'hFF), byte_beat(8'hFF)};
        send_list(q, 0);
        wait_idle();

        write_register(REG_TIMEOUT_TICKS, 32'd0);
        write_register(REG_MAX_FRAME_LEN, 32'd6);
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_TICK, 8'hFF);
        send_beat(CMD_START, 8'h00);
        q = {byte_beat(HDR_BYTE), byte_beat(HDR_BYTE), byte_beat(8'h12)};
        send_list(q, 0);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_START, 8'h00);
        send_list(build_frame(8'h07, 8'h09, 8'd3, 0, 9'h000), 0);
        send_beat(CMD_START, 8'h00);
        q = {byte_beat(HDR_BYTE), byte_beat(HDR_BYTE), byte_beat(8'h07), byte_beat(8'h04)};
        send_list(q, 0);
        wait_idle();

        write_register(REG_TIMEOUT_TICKS, 32'hFFFF);
        write_register(REG_MAX_FRAME_LEN, 32'd3);
        send_beat(CMD_START, 8'h00);
        q = {byte_beat(HDR_BYTE), byte_beat(HDR_BYTE), byte_beat(8'h01), byte_beat(8'h03)};
        send_list(q, 0);
        wait_idle();
        write_register(REG_MAX_FRAME_LEN, 32'd31);
        send_beat(CMD_START, 8'h00);
        send_list(build_frame(8'hFF, 8'hFF, 8'd13, 10, 9'h0FF), 0);
        send_beat(CMD_START, 8'h00);
        q = build_frame(8'h80, 8'h01, 8'd13, 10, 9'h000);
        q[q.size() - 1].data = ~q[q.size() - 1].data;
        send_list(q, 0);
        wait_idle();

        random_phase(16'd100, 5'd16, 10, 90, 1'b1);
        random_phase(16'd5, 5'd6, 8, 65, 1'b0);
        random_phase(16'hFFFF, 5'd11, 15, 65, 1'b1);
        random_phase(16'($urandom_range(0, 30)), 5'($urandom_range(6, 16)), 10, 65, 1'b0);
        random_phase(16'd0, 5'd16, 2, 70, 1'b0);

        $display("Sent %0d input beats and checked %0d result beats across %0d register writes.",
                 beats_sent, sb.beats_checked, reg_writes);
        $display("Good frames: %0d, error and timeout reports: %0d, mismatches: %0d.",
                 sb.good_frames, sb.reports, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_job_fifo.sv
rtl/core/sfr_front.sv
rtl/core/sfr_back.sv
rtl/core/servo_frame_receiver.sv
tb/servo_frame_receiver_test.sv
